>>> hw/rtl/tmp_pkg.sv
package tmp_pkg;

    // Configuration register indexes.
    localparam logic [7:0] REG_START_FREQUENCY = 8'd0;
    localparam logic [7:0] REG_TOP_FREQUENCY   = 8'd1;
    localparam logic [7:0] REG_FREQUENCY_STEP  = 8'd2;
    localparam logic [7:0] REG_STEPS_PER_STAIR = 8'd3;

    localparam int WORD_W    = 32;
    // The dividend of the per-move division is requested_steps / 2.
    localparam int HALF_W    = WORD_W - 1;
    localparam int CFG_IDX_W = 8;

    // Settled configuration as seen by the datapath.
    typedef struct packed {
        logic              err;
        logic [WORD_W-1:0] climb;
        logic [WORD_W-1:0] steps_per_stair;
    } plan_cfg_t;

    // One classified move between the front and the back.
    typedef struct packed {
        logic              err;
        logic [HALF_W-1:0] fit;
        logic [WORD_W-1:0] steps;
    } mid_item_t;

    // One finished plan.
    typedef struct packed {
        logic              err;
        logic [WORD_W-1:0] stairs;
        logic [WORD_W-1:0] cruise;
    } plan_result_t;

endpackage

>>> hw/rtl/tmp_cfg.sv
module tmp_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [tmp_pkg::WORD_W-1:0]          wr_data,
    output tmp_pkg::plan_cfg_t                  cfg,
    output logic                                busy
);

    localparam int W   = tmp_pkg::WORD_W;
    localparam int CW  = $clog2(W);

    logic [W-1:0]  start_reg;
    logic [W-1:0]  top_reg;
    logic [W-1:0]  fstep_reg;
    logic [W-1:0]  sps_reg;
    logic          busy_reg;
    logic          load_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  work_reg;

    logic [W:0]    trial;
    logic          ge;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  work_next;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            top_reg   <= '0;
            fstep_reg <= '0;
            sps_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tmp_pkg::REG_START_FREQUENCY: start_reg <= wr_data;
                tmp_pkg::REG_TOP_FREQUENCY:   top_reg   <= wr_data;
                tmp_pkg::REG_FREQUENCY_STEP:  fstep_reg <= wr_data;
                tmp_pkg::REG_STEPS_PER_STAIR: sps_reg   <= wr_data;
                default:                      ;
            endcase
        end
    end

    // One restoring step of the climb division per cycle.
    always_comb
    begin
        trial     = {rem_reg, work_reg[W-1]};
        ge        = (trial >= {1'b0, fstep_reg});
        rem_next  = ge ? W'(trial - {1'b0, fstep_reg}) : trial[W-1:0];
        work_next = {work_reg[W-2:0], ge};
    end

    // Climb divider sequencer: restarts on every register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (wr_en)
        begin
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            rem_reg  <= '0;
            work_reg <= top_reg - start_reg;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign cfg.err = (sps_reg == '0) || (fstep_reg == '0) ||
                     (start_reg > top_reg) || (fstep_reg > top_reg);
    assign cfg.climb           = work_reg;
    assign cfg.steps_per_stair = sps_reg;
    assign busy                = busy_reg;

endmodule

>>> hw/rtl/tmp_front.sv
module tmp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmp_pkg::plan_cfg_t            cfg,
    input  logic                          in_valid,
    input  logic [tmp_pkg::WORD_W-1:0]    in_steps,
    output logic                          out_valid,
    output tmp_pkg::mid_item_t            out_item
);

    localparam int W = tmp_pkg::WORD_W;
    localparam int H = tmp_pkg::HALF_W;

    // Stage i holds the move after i+1 quotient bits have been resolved.
    logic         v_reg     [H];
    logic         err_reg   [H];
    logic [W-1:0] rem_reg   [H];
    logic [H-1:0] work_reg  [H];
    logic [W-1:0] steps_reg [H];

    genvar i;
    generate
        for (i = 0; i < H; i++)
        begin : g_stage
            logic         v_in;
            logic         err_in;
            logic [W-1:0] rem_in;
            logic [H-1:0] work_in;
            logic [W-1:0] steps_in;
            logic [W:0]   trial;
            logic         ge;

            if (i == 0)
            begin : g_first
                assign v_in     = in_valid;
                assign err_in   = cfg.err;
                assign rem_in   = '0;
                assign work_in  = in_steps[W-1:1];
                assign steps_in = in_steps;
            end
            else
            begin : g_rest
                assign v_in     = v_reg[i-1];
                assign err_in   = err_reg[i-1];
                assign rem_in   = rem_reg[i-1];
                assign work_in  = work_reg[i-1];
                assign steps_in = steps_reg[i-1];
            end

            // Bring down the next dividend bit and try the subtraction.
            assign trial = {rem_in, work_in[H-1]};
            assign ge    = (trial >= {1'b0, cfg.steps_per_stair});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else
                begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                err_reg[i]   <= err_in;
                rem_reg[i]   <= ge ? W'(trial - {1'b0, cfg.steps_per_stair})
                                   : trial[W-1:0];
                work_reg[i]  <= {work_in[H-2:0], ge};
                steps_reg[i] <= steps_in;
            end
        end
    endgenerate

    assign out_valid      = v_reg[H-1];
    assign out_item.err   = err_reg[H-1];
    assign out_item.fit   = work_reg[H-1];
    assign out_item.steps = steps_reg[H-1];

endmodule

>>> hw/rtl/tmp_mid_queue.sv
module tmp_mid_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  tmp_pkg::mid_item_t   wr_item,
    input  logic                 rd_en,
    output logic                 not_empty,
    output tmp_pkg::mid_item_t   rd_item
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    tmp_pkg::mid_item_t slot_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               do_rd;

    assign do_rd     = rd_en && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign rd_item   = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(wr_en) - (AW+1)'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> hw/rtl/tmp_back.sv
module tmp_back
#(
    parameter int DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmp_pkg::plan_cfg_t    cfg,
    input  logic                  in_valid,
    input  tmp_pkg::mid_item_t    in_item,
    output logic                  out_valid,
    output tmp_pkg::plan_result_t out_result,
    input  logic                  out_pop
);

    localparam int W  = tmp_pkg::WORD_W;
    localparam int AW = $clog2(DEPTH);

    logic               s1_valid_reg;
    logic               s1_err_reg;
    logic [W-1:0]       s1_stairs_reg;
    logic [2*W-1:0]     s1_prod_reg;
    logic [W-1:0]       s1_steps_reg;

    logic [W-1:0]       fit_word;
    logic [W-1:0]       stairs_min;
    logic [2*W:0]       both_ramps;
    tmp_pkg::plan_result_t res;

    tmp_pkg::plan_result_t mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               ov_reg;
    tmp_pkg::plan_result_t dout_reg;
    logic               do_pop;
    logic               do_load;

    // Stage one: pick the stair count and multiply out the ramp length.
    assign fit_word   = {1'b0, in_item.fit};
    assign stairs_min = (cfg.climb >= fit_word) ? fit_word : cfg.climb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg    <= in_item.err;
        s1_stairs_reg <= stairs_min;
        s1_prod_reg   <= stairs_min * cfg.steps_per_stair;
        s1_steps_reg  <= in_item.steps;
    end

    // Stage two: cruise steps, with the ramps dropped if they overrun the move, and all zeros for an error plan.
    always_comb
    begin
        both_ramps = {s1_prod_reg, 1'b0};
        if (s1_err_reg)
        begin
            res.err    = 1'b1;
            res.stairs = '0;
            res.cruise = '0;
        end
        else if (both_ramps > {{(W+1){1'b0}}, s1_steps_reg})
        begin
            res.err    = 1'b0;
            res.stairs = '0;
            res.cruise = s1_steps_reg;
        end
        else
        begin
            res.err    = 1'b0;
            res.stairs = s1_stairs_reg;
            res.cruise = s1_steps_reg - both_ramps[W-1:0];
        end
    end

    // Result queue: memory with a registered head that drives the ports.
    assign do_pop  = out_pop && ov_reg;
    assign do_load = (count_reg != '0) && (!ov_reg || do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_load)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                ov_reg     <= 1'b1;
            end
            else if (do_pop)
            begin
                ov_reg <= 1'b0;
            end
            count_reg <= count_reg + (AW+1)'(s1_valid_reg) - (AW+1)'(do_load);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mem[wr_ptr_reg] <= res;
        end
        if (do_load)
        begin
            dout_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid  = ov_reg;
    assign out_result = dout_reg;

endmodule

>>> hw/rtl/trapezoid_move_planner.sv
// Trapezoidal move planner. Each pushed requested_steps yields one plan
// (plan_error, accel_stairs, decel_stairs, cruise_steps) in push order, and
// a new move is taken every cycle while full is low. On its way to the
// result ports, a move first passes 31 register stages in the pipelined
// divider that finds how many stairs fit in half the move. The first of
// these stages captures the move itself. It then passes one register each
// in the queue between front and back, the multiplier stage, the result
// memory and the result head register. Up to RESULT_DEPTH moves may be in
// flight or waiting; full rises when that many are outstanding, so
// RESULT_DEPTH must be a power of two of at least 64 for one move per
// cycle. Every configuration write starts a division of (top - start) by
// the frequency step, during which full is held high, so no move is taken
// until the division has finished. Configuration writes are always ready.
module trapezoid_move_planner
#(
    parameter int RESULT_DEPTH = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [tmp_pkg::WORD_W-1:0]      requested_steps,
    output logic                            empty,
    input  logic                            pop,
    output logic                            plan_error,
    output logic [tmp_pkg::WORD_W-1:0]      accel_stairs,
    output logic [tmp_pkg::WORD_W-1:0]      decel_stairs,
    output logic [tmp_pkg::WORD_W-1:0]      cruise_steps,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmp_pkg::WORD_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    tmp_pkg::plan_cfg_t    cfg;
    tmp_pkg::mid_item_t    front_item;
    tmp_pkg::mid_item_t    mid_item;
    tmp_pkg::plan_result_t result;
    logic                  cfg_busy;
    logic                  push_fire;
    logic                  pop_fire;
    logic                  front_valid;
    logic                  mid_not_empty;
    logic                  res_valid;
    logic [CNT_W-1:0]      inflight_reg;

    assign cfg_ready = 1'b1;
    assign push_fire = push && !full;
    assign pop_fire  = pop && res_valid;

    // Count moves between push and pop so the result queue never overflows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + CNT_W'(push_fire) - CNT_W'(pop_fire);
        end
    end

    assign full = cfg_busy || (inflight_reg == CNT_W'(RESULT_DEPTH));

    tmp_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .busy     (cfg_busy)
    );

    tmp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (push_fire),
        .in_steps  (requested_steps),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    tmp_mid_queue u_mid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_valid),
        .wr_item   (front_item),
        .rd_en     (1'b1),
        .not_empty (mid_not_empty),
        .rd_item   (mid_item)
    );

    tmp_back #(.DEPTH(RESULT_DEPTH)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (mid_not_empty),
        .in_item    (mid_item),
        .out_valid  (res_valid),
        .out_result (result),
        .out_pop    (pop)
    );

    assign empty        = !res_valid;
    assign plan_error   = result.err;
    assign accel_stairs = result.stairs;
    assign decel_stairs = result.stairs;
    assign cruise_steps = result.cruise;

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD   = 6;
    localparam int  RESET_CYCLES  = 8;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  RANDOM_MOVES  = 1050;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam logic [tmp_pkg::CFG_IDX_W-1:0] REG_LAST = tmp_pkg::REG_STEPS_PER_STAIR;

    // Expected plans and the predictor's own copy of the configuration.
    class plan_board;
        logic [tmp_pkg::WORD_W-1:0] start_freq;
        logic [tmp_pkg::WORD_W-1:0] top_freq;
        logic [tmp_pkg::WORD_W-1:0] freq_step;
        logic [tmp_pkg::WORD_W-1:0] stair_len;
        tmp_pkg::plan_result_t      plans_due[$];
        int                         failures;

        function new();
            start_freq = '0;
            top_freq   = '0;
            freq_step  = '0;
            stair_len  = '0;
            failures   = 0;
        endfunction

        function void write_reg(logic [tmp_pkg::CFG_IDX_W-1:0] idx,
                                logic [tmp_pkg::WORD_W-1:0] data);
            case (idx)
                tmp_pkg::REG_START_FREQUENCY: start_freq = data;
                tmp_pkg::REG_TOP_FREQUENCY:   top_freq   = data;
                tmp_pkg::REG_FREQUENCY_STEP:  freq_step  = data;
                tmp_pkg::REG_STEPS_PER_STAIR: stair_len  = data;
                default: ;
            endcase
        endfunction

        // Work out the plan for one accepted move.
        function void note_move(logic [tmp_pkg::WORD_W-1:0] steps);
            tmp_pkg::plan_result_t      plan;
            logic [tmp_pkg::WORD_W-1:0] climb;
            logic [tmp_pkg::WORD_W-1:0] fit;
            logic [tmp_pkg::WORD_W-1:0] stairs;
            logic [63:0]                both_ramps;
            plan = '0;
            if (stair_len == 0 || freq_step == 0 || start_freq > top_freq ||
                freq_step > top_freq)
            begin
                plan.err = 1'b1;
            end
            else
            begin
                climb  = (top_freq - start_freq) / freq_step;
                fit    = (steps >> 1) / stair_len;
                stairs = (climb >= fit) ? fit : climb;
                both_ramps = 64'(stairs) * 64'(stair_len) * 64'd2;
                if (both_ramps > 64'(steps))
                begin
                    plan.stairs = '0;
                    plan.cruise = steps;
                end
                else
                begin
                    plan.stairs = stairs;
                    plan.cruise = steps - both_ramps[tmp_pkg::WORD_W-1:0];
                end
            end
            plans_due.push_back(plan);
        endfunction

        function void check_plan(logic err, logic [tmp_pkg::WORD_W-1:0] accel,
                                 logic [tmp_pkg::WORD_W-1:0] decel,
                                 logic [tmp_pkg::WORD_W-1:0] cruise);
            tmp_pkg::plan_result_t plan;
            if (plans_due.size() == 0)
            begin
                $error("plan received with none outstanding");
                failures++;
                return;
            end
            plan = plans_due.pop_front();
            if (err !== plan.err)
            begin
                $error("plan_error: expected %0d, got %0d", plan.err, err);
                failures++;
            end
            if (accel !== plan.stairs)
            begin
                $error("accel_stairs: expected %0d, got %0d", plan.stairs, accel);
                failures++;
            end
            if (decel !== plan.stairs)
            begin
                $error("decel_stairs: expected %0d, got %0d", plan.stairs, decel);
                failures++;
            end
            if (cruise !== plan.cruise)
            begin
                $error("cruise_steps: expected %0d, got %0d", plan.cruise, cruise);
                failures++;
            end
        endfunction

        function int outstanding();
            return plans_due.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [tmp_pkg::WORD_W-1:0]    requested_steps;
    logic                          empty;
    logic                          pop;
    logic                          plan_error;
    logic [tmp_pkg::WORD_W-1:0]    accel_stairs;
    logic [tmp_pkg::WORD_W-1:0]    decel_stairs;
    logic [tmp_pkg::WORD_W-1:0]    cruise_steps;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tmp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tmp_pkg::WORD_W-1:0]    cfg_data;

    plan_board board = new();
    longint    cycles = 0;
    int        moves_sent = 0;

    trapezoid_move_planner u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .requested_steps (requested_steps),
        .empty           (empty),
        .pop             (pop),
        .plan_error      (plan_error),
        .accel_stairs    (accel_stairs),
        .decel_stairs    (decel_stairs),
        .cruise_steps    (cruise_steps),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly short idle stretches with the occasional long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls on pop, each transfer checked.
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            board.check_plan(plan_error, accel_stairs, decel_stairs, cruise_steps);
        end
    end

    // One move transfer, then an optional gap with push low.
    task automatic send_move(logic [tmp_pkg::WORD_W-1:0] steps);
        int gap;
        @(negedge clk);
        push            <= 1'b1;
        requested_steps <= steps;
        do
            @(posedge clk);
        while (full);
        board.note_move(steps);
        moves_sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending, then hold off until every plan is back and the pipeline
    // has drained.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; callers issue it only once no plans are outstanding, and the task itself does not wait for this.
    task automatic write_reg(logic [tmp_pkg::CFG_IDX_W-1:0] idx,
                             logic [tmp_pkg::WORD_W-1:0] data);
        @(negedge clk);
        push      <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_profile(logic [tmp_pkg::WORD_W-1:0] start_f,
                               logic [tmp_pkg::WORD_W-1:0] top_f,
                               logic [tmp_pkg::WORD_W-1:0] step_f,
                               logic [tmp_pkg::WORD_W-1:0] stair);
        wait_drained();
        write_reg(tmp_pkg::REG_START_FREQUENCY, start_f);
        write_reg(tmp_pkg::REG_TOP_FREQUENCY, top_f);
        write_reg(tmp_pkg::REG_FREQUENCY_STEP, step_f);
        write_reg(tmp_pkg::REG_STEPS_PER_STAIR, stair);
    endtask

    function automatic logic [tmp_pkg::WORD_W-1:0] random_steps();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom_range(0, 2000);
        else if (pick < 8)
            return $urandom >> $urandom_range(0, 31);
        return $urandom;
    endfunction

    initial
    begin
        logic [tmp_pkg::WORD_W-1:0] start_f;
        logic [tmp_pkg::WORD_W-1:0] top_f;
        logic [tmp_pkg::WORD_W-1:0] step_f;
        logic [tmp_pkg::WORD_W-1:0] stair;
        logic [63:0]                wide_top;
        int                         burst;

        rst_n           = 1'b0;
        push            = 1'b0;
        requested_steps = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration is invalid: every plan flags an error.
        send_move(32'd100);
        send_move(32'hFFFF_FFFF);

        // Climb of ten stairs, three steps per stair.
        set_profile(32'd100, 32'd1100, 32'd100, 32'd3);
        send_move(32'd0);
        send_move(32'd1);
        send_move(32'd6);
        send_move(32'd7);
        send_move(32'd59);
        send_move(32'd60);
        send_move(32'd61);
        send_move(32'd1000);
        send_move(32'hFFFF_FFFE);

        // Writes to unmapped indexes leave the plan unchanged.
        wait_drained();
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(tmp_pkg::CFG_IDX_W'(REG_LAST + 1), 32'd0);
        send_move(32'd61);

        // Each invalid case on its own.
        set_profile(32'd100, 32'd1100, 32'd100, 32'd0);
        send_move(32'd500);
        set_profile(32'd100, 32'd1100, 32'd0, 32'd3);
        send_move(32'd500);
        set_profile(32'd1200, 32'd1100, 32'd100, 32'd3);
        send_move(32'd500);
        set_profile(32'd0, 32'd100, 32'd101, 32'd3);
        send_move(32'd500);

        // Widest values: longest climb and stairs.
        set_profile(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1);
        send_move(32'hFFFF_FFFF);
        send_move(32'd2);
        set_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_move(32'hFFFF_FFFF);
        send_move(32'd0);

        // Random profiles, each followed by a burst of moves.
        while (moves_sent < RANDOM_MOVES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                start_f = $urandom;
                top_f   = $urandom;
                step_f  = $urandom >> $urandom_range(0, 31);
                stair   = $urandom >> $urandom_range(0, 31);
            end
            else
            begin
                start_f  = $urandom >> $urandom_range(0, 31);
                wide_top = 64'(start_f) + 64'($urandom_range(0, 100000));
                top_f    = (wide_top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide_top[31:0];
                step_f   = $urandom_range(1, 5000);
                if (step_f > top_f)
                    step_f = (top_f == 0) ? 32'd1 : top_f;
                stair = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 64);
                if (stair == 0)
                    stair = 32'd1;
            end
            set_profile(start_f, top_f, step_f, stair);
            if ($urandom_range(0, 5) == 0)
                write_reg(tmp_pkg::CFG_IDX_W'($urandom_range(REG_LAST + 1, 255)), $urandom);
            burst = $urandom_range(20, 60);
            repeat (burst)
                send_move(random_steps());
        end

        // Let the last plans come back.
        @(negedge clk);
        push <= 1'b0;
        wait_drained();
        if (board.failures == 0 && board.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/tmp_pkg.sv
hw/rtl/tmp_cfg.sv
hw/rtl/tmp_front.sv
hw/rtl/tmp_mid_queue.sv
hw/rtl/tmp_back.sv
hw/rtl/trapezoid_move_planner.sv
dv/tb.sv
